// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on the rising edge, off during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on the rising edge, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/tphd_pkg.sv =====
// Shared constants, codes and types of the heater drive.
package tphd_pkg;

  // Width of millisecond time stamps
  localparam int TIME_BITS = 40;

  // Datapath widths
  localparam int PROD_W = 26;   // 16 x 10 bit product
  localparam int DVD_W  = 17;   // phase + elapsed

  localparam logic [9:0] PERMILLE_FULL = 10'd1000;

  // Step counts of the shared unit
  localparam logic [4:0] MUL_STEPS = 5'd10;
  localparam logic [4:0] MOD_STEPS = 5'd17;

  // Register reset values
  localparam logic [15:0] WINDOW_RST = 16'd1000;
  localparam logic [15:0] MINP_RST   = 16'd20;
  localparam logic [15:0] STALE_RST  = 16'd2000;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_MINP   = 2'd1;
  localparam logic [1:0] REG_STALE  = 2'd2;

  // Event kinds
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_OFF     = 2'd2,
    REQ_RESTART = 2'd3
  } req_kind_t;

  // Shared unit operations
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_MOD = 1'b1
  } mdu_op_t;

  // Request into the shared unit
  typedef struct packed {
    logic              start;
    mdu_op_t           op;
    logic [DVD_W-1:0]  opa;   // multiplier in [9:0], or dividend
    logic [15:0]       opb;   // multiplicand, or divisor
  } mdu_req_t;

  // Response from the shared unit
  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] result;
  } mdu_rsp_t;

endpackage

// ===== design/tphd_if.sv =====
// Event and result channel interfaces of the heater drive.
interface tphd_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic [15:0]                    duty_request;
  logic [15:0]                    elapsed_ms;
  logic [tphd_pkg::TIME_BITS-1:0] now_ms;

  modport source (output valid, req_type, duty_request, elapsed_ms, now_ms, input ready);
  modport sink   (input valid, req_type, duty_request, elapsed_ms, now_ms, output ready);
endinterface

interface tphd_out_if;
  logic       valid;
  logic       ready;
  logic       heater_on;
  logic [9:0] duty_in_use;
  logic       stale_forced_off;

  modport source (output valid, heater_on, duty_in_use, stale_forced_off, input ready);
  modport sink   (input valid, heater_on, duty_in_use, stale_forced_off, output ready);
endinterface

// ===== design/tphd_mdu.sv =====
// Shared iterative unit: shift-add multiply and restoring remainder on one adder.
module tphd_mdu (
  input  logic                clk,
  input  logic                rst_n,
  input  tphd_pkg::mdu_req_t  req,
  output tphd_pkg::mdu_rsp_t  rsp
);

  tphd_pkg::mdu_op_t                  op_r, op_nxt;
  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [4:0]                         cnt_r, cnt_nxt;
  logic [tphd_pkg::PROD_W-1:0]        acc_r, acc_nxt;     // product, or remainder in [15:0]
  logic [tphd_pkg::PROD_W-1:0]        mcand_r, mcand_nxt; // shifted multiplicand, or divisor
  logic [tphd_pkg::DVD_W-1:0]         shf_r, shf_nxt;     // multiplier bits, or dividend bits

  logic [tphd_pkg::PROD_W:0]          add_x, add_y, add_sum;
  logic                               add_sub;

  // One adder: accumulate for multiply, trial subtract for remainder
  always_comb begin
    add_sub = (op_r == tphd_pkg::OP_MOD);
    if (add_sub) begin
      add_x = {10'b0, acc_r[15:0], shf_r[tphd_pkg::DVD_W-1]};
      add_y = {11'b0, mcand_r[15:0]};
    end else begin
      add_x = {1'b0, acc_r};
      add_y = {1'b0, mcand_r};
    end
    add_sum = add_x + (add_sub ? ~add_y : add_y) + {{tphd_pkg::PROD_W{1'b0}}, add_sub};
  end

  // Step sequencing
  always_comb begin
    op_nxt    = op_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    shf_nxt   = shf_r;
    if (req.start) begin
      op_nxt    = req.op;
      busy_nxt  = 1'b1;
      acc_nxt   = '0;
      mcand_nxt = {10'b0, req.opb};
      if (req.op == tphd_pkg::OP_MUL) begin
        cnt_nxt = tphd_pkg::MUL_STEPS;
        shf_nxt = {7'b0, req.opa[9:0]};
      end else begin
        cnt_nxt = tphd_pkg::MOD_STEPS;
        shf_nxt = req.opa;
      end
    end else if (busy_r) begin
      unique case (op_r)
        tphd_pkg::OP_MUL: begin
          if (shf_r[0]) begin
            acc_nxt = add_sum[tphd_pkg::PROD_W-1:0];
          end
          mcand_nxt = {mcand_r[tphd_pkg::PROD_W-2:0], 1'b0};
          shf_nxt   = {1'b0, shf_r[tphd_pkg::DVD_W-1:1]};
        end
        tphd_pkg::OP_MOD: begin
          // sign bit clear: partial remainder >= divisor
          if (!add_sum[tphd_pkg::PROD_W]) begin
            acc_nxt = {10'b0, add_sum[15:0]};
          end else begin
            acc_nxt = {10'b0, add_x[15:0]};
          end
          shf_nxt = {shf_r[tphd_pkg::DVD_W-2:0], 1'b0};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= tphd_pkg::OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    shf_r   <= shf_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

endmodule

// ===== design/time_proportioning_heater_drive.sv =====
// Top level: event sequencer, state, config registers and result word register.
//
//  Channel  Dir  Handshake               Content
//  in_ch    in   valid/ready             event word: req_type, duty_request, elapsed_ms, now_ms
//  out_ch   out  valid/ready             result word: heater_on, duty_in_use, stale_forced_off
//  APB      in   psel/penable, pready=1  window_length_ms, shortest_pulse_ms, stale_limit_ms
//
// One event at a time; in_ch.ready is high only while the sequencer is idle.
// Restart and force-off pass through decode to the result register, a stale tick as well.
// Set duty runs three 10-step multiplies, or stops after two when snapped to zero;
// a live tick runs a 17-step remainder plus two 10-step multiplies.
// A waiting result word does not block intake; only the next result waits on out_ch.ready.
// Synchronous active-low reset; no clearing pass.
`include "assert_macros.svh"

module time_proportioning_heater_drive (
  input  logic              clk,
  input  logic              rst_n,
  tphd_in_if.sink           in_ch,
  tphd_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SD_A,
    S_SD_B,
    S_SD_C,
    S_TK_MOD,
    S_TK_M1,
    S_TK_M2,
    S_OUT
  } state_t;

  state_t                         state_r, state_nxt;

  // Config registers
  logic [15:0]                    win_r, minp_r, stale_lim_r;
  logic [15:0]                    win_eff;
  logic                           cfg_wr;

  // Latched event word
  tphd_pkg::req_kind_t            kind_r;
  logic [15:0]                    req_r;
  logic [15:0]                    dt_r;
  logic [tphd_pkg::TIME_BITS-1:0] now_r;

  // Drive state
  logic [9:0]                     duty_r, duty_nxt;
  logic [15:0]                    phase_r, phase_nxt;
  logic [tphd_pkg::TIME_BITS-1:0] last_r, last_nxt;
  logic                           drive_r, drive_nxt;
  logic                           stale_r, stale_nxt;

  // Scratch
  logic [9:0]                     p_r, p_nxt;
  logic [tphd_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  logic [tphd_pkg::PROD_W-1:0]    bound_r, bound_nxt;

  // Result word register
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_heater_r, out_heater_nxt;
  logic [9:0]                     out_duty_r, out_duty_nxt;
  logic                           out_stale_r, out_stale_nxt;

  tphd_pkg::mdu_req_t             mdu_req;
  tphd_pkg::mdu_rsp_t             mdu_rsp;

  logic [tphd_pkg::TIME_BITS-1:0] age;
  logic                           is_stale;
  logic [9:0]                     req_clamp;
  logic                           in_acc;

  tphd_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .rsp   (mdu_rsp)
  );

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      tphd_pkg::REG_WINDOW: prdata = {16'b0, win_r};
      tphd_pkg::REG_MINP:   prdata = {16'b0, minp_r};
      tphd_pkg::REG_STALE:  prdata = {16'b0, stale_lim_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= tphd_pkg::WINDOW_RST;
      minp_r      <= tphd_pkg::MINP_RST;
      stale_lim_r <= tphd_pkg::STALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tphd_pkg::REG_WINDOW: win_r       <= pwdata[15:0];
        tphd_pkg::REG_MINP:   minp_r      <= pwdata[15:0];
        tphd_pkg::REG_STALE:  stale_lim_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // A zero window behaves as one millisecond
  assign win_eff = (win_r == 16'd0) ? 16'd1 : win_r;

  // Age of the last update; time running backwards counts as zero age
  assign age      = now_r - last_r;
  assign is_stale = (now_r >= last_r) &&
                    (age > {{(tphd_pkg::TIME_BITS-16){1'b0}}, stale_lim_r});

  assign req_clamp = (req_r > {6'b0, tphd_pkg::PERMILLE_FULL}) ? tphd_pkg::PERMILLE_FULL
                                                                : req_r[9:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Event latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= tphd_pkg::req_kind_t'(in_ch.req_type);
      req_r  <= in_ch.duty_request;
      dt_r   <= in_ch.elapsed_ms;
      now_r  <= in_ch.now_ms;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    duty_nxt       = duty_r;
    phase_nxt      = phase_r;
    last_nxt       = last_r;
    drive_nxt      = drive_r;
    stale_nxt      = stale_r;
    p_nxt          = p_r;
    prod_nxt       = prod_r;
    bound_nxt      = bound_r;
    out_valid_nxt  = out_valid_r;
    out_heater_nxt = out_heater_r;
    out_duty_nxt   = out_duty_r;
    out_stale_nxt  = out_stale_r;
    mdu_req.start  = 1'b0;
    mdu_req.op     = tphd_pkg::OP_MUL;
    mdu_req.opa    = '0;
    mdu_req.opb    = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        stale_nxt = 1'b0;
        unique case (kind_r)
          tphd_pkg::REQ_RESTART: begin
            duty_nxt  = '0;
            phase_nxt = '0;
            drive_nxt = 1'b0;
            last_nxt  = now_r;
            state_nxt = S_OUT;
          end
          tphd_pkg::REQ_OFF: begin
            duty_nxt  = '0;
            drive_nxt = 1'b0;
            last_nxt  = now_r;
            state_nxt = S_OUT;
          end
          tphd_pkg::REQ_SET: begin
            // on time: p * window
            p_nxt         = req_clamp;
            mdu_req.start = 1'b1;
            mdu_req.op    = tphd_pkg::OP_MUL;
            mdu_req.opa   = {7'b0, req_clamp};
            mdu_req.opb   = win_eff;
            state_nxt     = S_SD_A;
          end
          tphd_pkg::REQ_TICK: begin
            if (is_stale) begin
              duty_nxt  = '0;
              drive_nxt = 1'b0;
              stale_nxt = 1'b1;
              state_nxt = S_OUT;
            end else begin
              mdu_req.start = 1'b1;
              mdu_req.op    = tphd_pkg::OP_MOD;
              mdu_req.opa   = {1'b0, phase_r} + {1'b0, dt_r};
              mdu_req.opb   = win_eff;
              state_nxt     = S_TK_MOD;
            end
          end
          default: ;
        endcase
      end
      S_SD_A: begin
        if (mdu_rsp.done) begin
          // minimum pulse scaled by 1000
          prod_nxt      = mdu_rsp.result;
          mdu_req.start = 1'b1;
          mdu_req.op    = tphd_pkg::OP_MUL;
          mdu_req.opa   = {7'b0, tphd_pkg::PERMILLE_FULL};
          mdu_req.opb   = minp_r;
          state_nxt     = S_SD_B;
        end
      end
      S_SD_B: begin
        if (mdu_rsp.done) begin
          bound_nxt = mdu_rsp.result;
          if (prod_r < mdu_rsp.result) begin
            // on pulse too short: snap to off
            duty_nxt  = '0;
            last_nxt  = now_r;
            state_nxt = S_OUT;
          end else begin
            // off time: (1000 - p) * window
            mdu_req.start = 1'b1;
            mdu_req.op    = tphd_pkg::OP_MUL;
            mdu_req.opa   = {7'b0, tphd_pkg::PERMILLE_FULL - p_r};
            mdu_req.opb   = win_eff;
            state_nxt     = S_SD_C;
          end
        end
      end
      S_SD_C: begin
        if (mdu_rsp.done) begin
          // off pulse too short: snap to full on
          duty_nxt  = (mdu_rsp.result < bound_r) ? tphd_pkg::PERMILLE_FULL : p_r;
          last_nxt  = now_r;
          state_nxt = S_OUT;
        end
      end
      S_TK_MOD: begin
        if (mdu_rsp.done) begin
          phase_nxt     = mdu_rsp.result[15:0];
          mdu_req.start = 1'b1;
          mdu_req.op    = tphd_pkg::OP_MUL;
          mdu_req.opa   = {7'b0, tphd_pkg::PERMILLE_FULL};
          mdu_req.opb   = mdu_rsp.result[15:0] + 16'd1;
          state_nxt     = S_TK_M1;
        end
      end
      S_TK_M1: begin
        if (mdu_rsp.done) begin
          bound_nxt     = mdu_rsp.result;
          mdu_req.start = 1'b1;
          mdu_req.op    = tphd_pkg::OP_MUL;
          mdu_req.opa   = {7'b0, duty_r};
          mdu_req.opb   = win_eff;
          state_nxt     = S_TK_M2;
        end
      end
      S_TK_M2: begin
        if (mdu_rsp.done) begin
          // phase < duty*window/1000  <=>  1000*(phase+1) <= duty*window
          drive_nxt = (bound_r <= mdu_rsp.result);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_heater_nxt = drive_r;
          out_duty_nxt   = duty_r;
          out_stale_nxt  = stale_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      duty_r      <= '0;
      phase_r     <= '0;
      last_r      <= '0;
      drive_r     <= 1'b0;
      stale_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      duty_r      <= duty_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      drive_r     <= drive_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p_r          <= p_nxt;
    prod_r       <= prod_nxt;
    bound_r      <= bound_nxt;
    out_heater_r <= out_heater_nxt;
    out_duty_r   <= out_duty_nxt;
    out_stale_r  <= out_stale_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.heater_on        = out_heater_r;
  assign out_ch.duty_in_use      = out_duty_r;
  assign out_ch.stale_forced_off = out_stale_r;

  // Checks
  `ASSERT_IMPL(a_stale_off, clk, rst_n, out_valid_r && out_stale_r, !out_heater_r && (out_duty_r == 10'd0), "stale result with relay on or nonzero duty")
  `ASSERT_IMPL(a_duty_range, clk, rst_n, out_valid_r, out_duty_r <= tphd_pkg::PERMILLE_FULL, "duty above full scale")
  `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_acc, !in_ch.ready, "event taken while previous one in work")

endmodule
